// ===== sv/acmc_pkg.sv =====
// Package: shared types, codes and constants of the alarm clock mode controller.
package acmc_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned ModeW   = 3;

  localparam logic [HourW-1:0]   HoursPerDay    = HourW'(24);
  localparam logic [MinuteW-1:0] MinutesPerHour = MinuteW'(60);

  typedef enum logic [ModeW-1:0] {
    MODE_START   = 3'd0,
    MODE_SETTING = 3'd1,
    MODE_CLOCK   = 3'd2,
    MODE_ARMED   = 3'd3,
    MODE_RINGING = 3'd4
  } mode_e;

  typedef enum logic [OpW-1:0] {
    EV_ROTARY   = 2'd0,
    EV_JOYSTICK = 2'd1,
    EV_COMPARE  = 2'd2,
    EV_TIMEOUT  = 2'd3
  } op_e;

  // Input event word as held in the input register
  typedef struct packed {
    op_e                op;
    logic [HourW-1:0]   now_hour;
    logic [MinuteW-1:0] now_minute;
  } event_t;

  // Architectural state of the mode machine
  typedef struct packed {
    mode_e              mode;
    logic [HourW-1:0]   alarm_hour;
    logic [MinuteW-1:0] alarm_minute;
    logic               hour_done;
    logic               armed;
    logic               running;
    logic               display;
  } state_t;

  // One-event pulses
  typedef struct packed {
    logic load;
    logic ring;
  } pulse_t;

endpackage

// ===== sv/acmc_if.sv =====
// Interfaces: event channel and result channel with valid/ready handshake.
interface acmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [acmc_pkg::OpW-1:0]      opcode;
  logic [acmc_pkg::HourW-1:0]    now_hour;
  logic [acmc_pkg::MinuteW-1:0]  now_minute;

  modport source (output valid, output opcode, output now_hour, output now_minute,
                  input ready);
  modport sink   (input valid, input opcode, input now_hour, input now_minute,
                  output ready);
endinterface

interface acmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [acmc_pkg::ModeW-1:0]    mode;
  logic [acmc_pkg::HourW-1:0]    set_hour;
  logic [acmc_pkg::MinuteW-1:0]  set_minute;
  logic                          editing_minute;
  logic                          alarm_armed;
  logic                          clock_running;
  logic                          load_clock;
  logic                          show_clock;
  logic                          ring_start;
  logic                          ringing;

  modport source (output valid, output mode, output set_hour, output set_minute,
                  output editing_minute, output alarm_armed, output clock_running,
                  output load_clock, output show_clock, output ring_start,
                  output ringing, input ready);
  modport sink   (input valid, input mode, input set_hour, input set_minute,
                  input editing_minute, input alarm_armed, input clock_running,
                  input load_clock, input show_clock, input ring_start,
                  input ringing, output ready);
endinterface

// ===== sv/acmc_fsm.sv =====
// Mode machine: next state and event pulses for one event word.
module acmc_fsm (
  input  acmc_pkg::state_t state_i,
  input  acmc_pkg::event_t event_i,
  output acmc_pkg::state_t state_o,
  output acmc_pkg::pulse_t pulse_o
);
  import acmc_pkg::*;

  logic [HourW-1:0]   hour_inc;
  logic [MinuteW-1:0] minute_inc;
  logic               time_hit;

  // Wrapping increments of the set time
  assign hour_inc   = (state_i.alarm_hour == HoursPerDay - HourW'(1)) ? '0
                    : state_i.alarm_hour + HourW'(1);
  assign minute_inc = (state_i.alarm_minute == MinutesPerHour - MinuteW'(1)) ? '0
                    : state_i.alarm_minute + MinuteW'(1);

  assign time_hit = state_i.armed
                 && (event_i.now_hour == state_i.alarm_hour)
                 && (event_i.now_minute == state_i.alarm_minute);

  // Next state
  always_comb begin
    state_o = state_i;
    unique case (state_i.mode)
      MODE_SETTING: begin
        if (event_i.op == EV_ROTARY) begin
          if (state_i.hour_done) state_o.alarm_minute = minute_inc;
          else                   state_o.alarm_hour   = hour_inc;
          state_o.display = 1'b0;
        end else if (event_i.op == EV_JOYSTICK) begin
          if (state_i.hour_done) begin
            state_o.hour_done = 1'b0;
            state_o.running   = 1'b1;
            state_o.mode      = MODE_CLOCK;
            state_o.display   = 1'b1;
          end else begin
            state_o.hour_done = 1'b1;
            state_o.display   = 1'b0;
          end
        end
      end
      MODE_CLOCK: begin
        if (event_i.op == EV_ROTARY) begin
          state_o.mode  = MODE_ARMED;
          state_o.armed = 1'b1;
        end else if (event_i.op == EV_JOYSTICK) begin
          state_o.mode    = MODE_SETTING;
          state_o.display = 1'b0;
        end
      end
      MODE_ARMED: begin
        if (event_i.op == EV_ROTARY) begin
          state_o.armed   = 1'b0;
          state_o.mode    = MODE_CLOCK;
          state_o.display = 1'b1;
        end else if (event_i.op == EV_JOYSTICK) begin
          // armed flag deliberately kept
          state_o.mode    = MODE_SETTING;
          state_o.display = 1'b0;
        end else if (event_i.op == EV_COMPARE && time_hit) begin
          state_o.mode = MODE_RINGING;
        end
      end
      MODE_RINGING: begin
        if (event_i.op != EV_COMPARE) begin
          state_o.mode  = MODE_ARMED;
          state_o.armed = 1'b1;
        end
      end
      default: begin
        if (event_i.op == EV_ROTARY) begin
          state_o.mode    = MODE_SETTING;
          state_o.display = 1'b0;
        end
      end
    endcase
  end

  // Pulses
  always_comb begin
    pulse_o.load = (state_i.mode == MODE_SETTING) && (event_i.op == EV_JOYSTICK)
                && state_i.hour_done && !state_i.running;
    pulse_o.ring = (state_i.mode == MODE_ARMED) && (event_i.op == EV_COMPARE)
                && time_hit;
  end

endmodule

// ===== sv/alarm_clock_mode_controller_unit.sv =====
// Top level: alarm clock mode controller with input and result registers.
//
//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+------------
//  in_i    | in  | opcode, now_hour, now_minute           | valid/ready
//  out_o   | out | mode, set time, flags, pulses, ringing | valid/ready
//
// One event per cycle while the result is not stalled; an accepted event passes
// the input register, then the mode update into the result register.
// The mode state is updated when the result register loads, so order holds.
// Reset puts the machine in start mode with all flags and the set time zero.
// A stalled result holds both stages; the input side stays ready while the
// input register is empty or moving.
module alarm_clock_mode_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  acmc_in_if.sink     in_i,
  acmc_out_if.source  out_o
);
  import acmc_pkg::*;

  logic     in_vld_q;
  event_t   ev_q;
  logic     out_vld_q;
  state_t   state_q, state_d;
  pulse_t   pulse_d, pulse_q;
  logic     out_adv;
  logic     in_adv;

  // Stage handshake
  assign out_adv  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_adv   = !in_vld_q || out_adv;
  assign in_i.ready = in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      ev_q.op         <= op_e'(in_i.opcode);
      ev_q.now_hour   <= in_i.now_hour;
      ev_q.now_minute <= in_i.now_minute;
    end
  end

  acmc_fsm u_fsm (
    .state_i (state_q),
    .event_i (ev_q),
    .state_o (state_d),
    .pulse_o (pulse_d)
  );

  // Mode state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= MODE_START;
      state_q.alarm_hour   <= '0;
      state_q.alarm_minute <= '0;
      state_q.hour_done    <= 1'b0;
      state_q.armed        <= 1'b0;
      state_q.running      <= 1'b0;
      state_q.display      <= 1'b0;
      out_vld_q            <= 1'b0;
    end else begin
      if (out_adv) begin
        state_q <= state_d;
      end
      if (out_adv)           out_vld_q <= 1'b1;
      else if (out_o.ready)  out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      pulse_q <= pulse_d;
    end
  end

  // Result word straight from the registers
  assign out_o.valid          = out_vld_q;
  assign out_o.mode           = ModeW'(state_q.mode);
  assign out_o.set_hour       = state_q.alarm_hour;
  assign out_o.set_minute     = state_q.alarm_minute;
  assign out_o.editing_minute = state_q.hour_done;
  assign out_o.alarm_armed    = state_q.armed;
  assign out_o.clock_running  = state_q.running;
  assign out_o.load_clock     = pulse_q.load;
  assign out_o.show_clock     = state_q.display;
  assign out_o.ring_start     = pulse_q.ring;
  assign out_o.ringing        = (state_q.mode == MODE_RINGING);

endmodule
